/* src/art_pkg.sv */
package art_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int MAX_TRIES   = 7;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = AW + 1;
  localparam int ID_W        = 32;
  localparam int TIME_W      = 48;
  localparam int RETRY_W     = 3;
  localparam int STEP_W      = 13;

  localparam logic [RETRY_W-1:0] MAX_TRIES_C = RETRY_W'(MAX_TRIES);
  localparam logic [CNT_W-1:0]   DEPTH_C     = CNT_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    FN_REG  = 2'd0,
    FN_ACK  = 2'd1,
    FN_TICK = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_REGISTERED = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_FULL       = 3'd2,
    ST_ACKED      = 3'd3,
    ST_UNMATCHED  = 3'd4,
    ST_RESEND     = 3'd5,
    ST_EXPIRED    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } seq_state_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  sent;
    logic [RETRY_W-1:0] retries;
  } slot_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    id;
    logic [RETRY_W-1:0] retries;
    logic               idle;
    logic               last;
  } res_t;

  typedef struct packed {
    logic               id_hit;
    logic               expired;
    logic               due;
    logic [RETRY_W-1:0] retries_inc;
  } cmp_t;

  // Backoff step in milliseconds for a given retry count.
  function automatic logic [STEP_W-1:0] backoff_ms(input logic [RETRY_W-1:0] r);
    logic [STEP_W-1:0] step;
    unique case (r)
      3'd0:    step = 13'd125;
      3'd1:    step = 13'd250;
      3'd2:    step = 13'd500;
      3'd3:    step = 13'd750;
      3'd4:    step = 13'd1000;
      3'd5:    step = 13'd2000;
      default: step = 13'd5000;
    endcase
    return step;
  endfunction

endpackage

/* src/art_slot_ram.sv */
module art_slot_ram
  import art_pkg::*;
(
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  slot_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output slot_t         rd_data
);

  slot_t mem [TABLE_DEPTH];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/art_cmp_unit.sv */
module art_cmp_unit
  import art_pkg::*;
(
  input  logic [ID_W-1:0]   item_id,
  input  logic [TIME_W-1:0] now,
  input  slot_t             slot,
  output cmp_t              cmp
);

  logic [TIME_W:0] deadline;

  // The deadline keeps its carry bit so that it never wraps.
  assign deadline        = {1'b0, slot.sent} + (TIME_W + 1)'(backoff_ms(slot.retries));
  assign cmp.id_hit      = (slot.id == item_id);
  assign cmp.expired     = (slot.retries >= MAX_TRIES_C);
  assign cmp.due         = ({1'b0, now} > deadline);
  assign cmp.retries_inc = slot.retries + RETRY_W'(1);

endmodule

/* src/art_seq.sv */
module art_seq
  import art_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [ID_W-1:0]   in_message_id,
  input  logic [TIME_W-1:0] in_time_ms,
  input  logic              push_ok,
  output logic              push,
  output res_t              push_res
);

  seq_state_t             state_r, state_nxt;
  func_t                  func_r, func_nxt;
  logic [ID_W-1:0]        id_r, id_nxt;
  logic [TIME_W-1:0]      time_r, time_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic                   hit_r, hit_nxt;
  logic [AW-1:0]          hit_idx_r, hit_idx_nxt;
  logic                   free_r, free_nxt;
  logic [AW-1:0]          free_idx_r, free_idx_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  res_t                   pend_r, pend_nxt;

  logic          rd_en, wr_en;
  logic [AW-1:0] wr_addr, ev_idx;
  slot_t         rd_data, wr_data;
  cmp_t          cmp;
  logic          ev_on, slot_live, tick_hit, adv;
  res_t          tick_res;

  art_slot_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (rd_data)
  );

  art_cmp_unit u_cmp (
    .item_id (id_r),
    .now     (time_r),
    .slot    (rd_data),
    .cmp     (cmp)
  );

  // The slot under evaluation is the one read in the previous advancing cycle.
  assign ev_on     = (cnt_r != '0);
  assign ev_idx    = AW'(cnt_r - CNT_W'(1));
  assign slot_live = ev_on && valid_r[ev_idx];
  assign tick_hit  = (func_r == FN_TICK) && slot_live && (cmp.expired || cmp.due);
  assign adv       = !(tick_hit && pend_vld_r && !push_ok);

  always_comb begin
    if (cmp.expired) begin
      tick_res = '{status: ST_EXPIRED, id: rd_data.id, retries: rd_data.retries,
                   idle: 1'b0, last: 1'b0};
    end else begin
      tick_res = '{status: ST_RESEND, id: rd_data.id, retries: cmp.retries_inc,
                   idle: 1'b0, last: 1'b0};
    end
  end

  always_comb begin
    state_nxt    = state_r;
    func_nxt     = func_r;
    id_nxt       = id_r;
    time_nxt     = time_r;
    cnt_nxt      = cnt_r;
    valid_nxt    = valid_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    in_stall     = 1'b1;
    push         = 1'b0;
    push_res     = pend_r;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = ev_idx;
    wr_data      = '{id: rd_data.id, sent: rd_data.sent, retries: cmp.retries_inc};

    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          func_nxt     = func_t'(in_func);
          id_nxt       = in_message_id;
          time_nxt     = in_time_ms;
          cnt_nxt      = '0;
          hit_nxt      = 1'b0;
          free_nxt     = 1'b0;
          pend_vld_nxt = 1'b0;
          if (func_t'(in_func) != FN_NONE) begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (adv) begin
          rd_en = (cnt_r < DEPTH_C);
          // The counter stops at the depth once the last slot has been evaluated.
          if (cnt_r == DEPTH_C) begin
            state_nxt = S_DONE;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (slot_live && cmp.id_hit && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = ev_idx;
          end
          if (ev_on && !valid_r[ev_idx] && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = ev_idx;
          end
          if (tick_hit) begin
            if (cmp.expired) begin
              valid_nxt[ev_idx] = 1'b0;
            end else begin
              wr_en = 1'b1;
            end
            // The held result goes out now; it cannot be the last one.
            push         = pend_vld_r;
            pend_vld_nxt = 1'b1;
            pend_nxt     = tick_res;
          end
        end
      end

      S_DONE: begin
        if (push_ok) begin
          push         = 1'b1;
          state_nxt    = S_IDLE;
          pend_vld_nxt = 1'b0;
          unique case (func_r)
            FN_REG: begin
              if (hit_r) begin
                push_res = '{status: ST_DUPLICATE, id: id_r, retries: '0, idle: 1'b0,
                             last: 1'b1};
              end else if (!free_r) begin
                push_res = '{status: ST_FULL, id: id_r, retries: '0, idle: 1'b0,
                             last: 1'b1};
              end else begin
                push_res = '{status: ST_REGISTERED, id: id_r, retries: '0, idle: 1'b0,
                             last: 1'b1};
                wr_en    = 1'b1;
                wr_addr  = free_idx_r;
                wr_data  = '{id: id_r, sent: time_r, retries: '0};
                valid_nxt[free_idx_r] = 1'b1;
              end
            end
            FN_ACK: begin
              if (hit_r) begin
                push_res = '{status: ST_ACKED, id: id_r, retries: '0, idle: 1'b0,
                             last: 1'b1};
                valid_nxt[hit_idx_r] = 1'b0;
              end else begin
                push_res = '{status: ST_UNMATCHED, id: id_r, retries: '0, idle: 1'b0,
                             last: 1'b1};
              end
            end
            FN_TICK: begin
              if (pend_vld_r) begin
                push_res      = pend_r;
                push_res.last = 1'b1;
              end else begin
                push_res = '{status: ST_EXPIRED, id: '0, retries: '0, idle: 1'b1,
                             last: 1'b1};
              end
            end
            FN_NONE: begin
              push = 1'b0;
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      valid_r    <= '0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      pend_vld_r <= 1'b0;
      func_r     <= FN_NONE;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      valid_r    <= valid_nxt;
      hit_r      <= hit_nxt;
      free_r     <= free_nxt;
      pend_vld_r <= pend_vld_nxt;
      func_r     <= func_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    time_r     <= time_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    pend_r     <= pend_nxt;
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_ok)
    else $error("result pushed while the output register was full");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_vld_r)
    else $error("pending tick result left behind in idle");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("scan counter ran past the table depth");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_res.last) |=> (state_r == S_IDLE))
    else $error("final result pushed but the sequencer did not return to idle");

  a_scan_only_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == S_SCAN) |-> (func_r == FN_TICK))
    else $error("table written during a register or ack search");

endmodule

/* src/ack_retransmit_tracker.sv */
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+---------------------------------------------
// input     | in        | in_valid / in_stall  | in_func, in_message_id, in_time_ms
// result    | out       | out_valid / out_stall| out_status, out_out_id, out_retry_count,
//           |           |                      | out_idle_tick, out_last
//
// A register, ack or tick transaction walks all TABLE_DEPTH slots through the single table
// read port, which visits one slot per cycle unless a result channel stall pauses the scan,
// and then waits for room for its final result. A transaction with func 3 produces nothing.
// Reset (synchronous, active low) clears only the slot valid bits and the control state;
// the slot memory itself is never cleared, so the block is ready right after reset.
// A stall on the result channel holds the output register and, if another result is
// waiting, pauses the scan; the input channel stalls while a transaction is in progress.
module ack_retransmit_tracker
  import art_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [ID_W-1:0]   in_message_id,
  input  logic [TIME_W-1:0] in_time_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [ID_W-1:0]   out_out_id,
  output logic [2:0]        out_retry_count,
  output logic              out_idle_tick,
  output logic              out_last
);

  // The output register decouples the sequencer from the result channel: a finished
  // result may sit here while the next input transaction is already being processed.
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r, out_res_nxt;
  logic push, push_ok;
  res_t push_res;

  // There is room when the register is empty or its content leaves this cycle.
  assign push_ok = !out_valid_r || !out_stall;

  art_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_message_id (in_message_id),
    .in_time_ms    (in_time_ms),
    .push_ok       (push_ok),
    .push          (push),
    .push_res      (push_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = push_res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_out_id      = out_res_r.id;
  assign out_retry_count = out_res_r.retries;
  assign out_idle_tick   = out_res_r.idle;
  assign out_last        = out_res_r.last;

endmodule
